>>> hdl/mfpq_pkg.sv
// ----------------------------------------------------------------------------
// mfpq_pkg
// Shared types and constants of the mixed FIFO / priority queue.
// ----------------------------------------------------------------------------
package mfpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 16;
  localparam int DATA_BITS   = 32;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  localparam logic [1:0] CMD_PUSH_TAIL = 2'd0;
  localparam logic [1:0] CMD_PUSH_PRIO = 2'd1;
  localparam logic [1:0] CMD_POP       = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data;
  } entry_t;

  typedef struct packed {
    logic [5:0]           pad;
    logic [DATA_BITS-1:0] item_data;
    logic [KEY_BITS-1:0]  item_key;
    logic [1:0]           cmd;
  } in_beat_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]  occupancy;
    logic [DATA_BITS-1:0] out_data;
    logic [KEY_BITS-1:0]  out_key;
    logic                 out_valid;
    logic [1:0]           status;
  } out_beat_t;

endpackage

>>> hdl/mixed_fifo_priority_queue.sv
// ----------------------------------------------------------------------------
// mixed_fifo_priority_queue
// Bounded queue of (key, data) entries with tail push, priority push and pop.
// ----------------------------------------------------------------------------
// Entries sit in a circular buffer memory with one write and one registered
// read port. Tail push, refused commands and cmd 3 are answered from idle;
// pop reads the head, then answers; a priority push that beats the head key
// goes in front of the head, else one comparator walks from the tail toward
// the head past each entry with a smaller key, moving one entry a cycle
// through the memory port while the result register can take a beat. The
// result beat sits in an output register; a command beat is taken only while
// no item is in work and that register is empty or read in the same cycle,
// so a stalled result beat holds off the input. No clearing pass after reset.
module mixed_fifo_priority_queue
  import mfpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cmd[1:0], item_key[17:2], item_data[49:18], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status[1:0], out_valid[2], out_key[18:3], out_data[50:19], occupancy[55:51]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_POP_RD   = 2'd1;
  localparam logic [1:0] S_HEAD_CHK = 2'd2;
  localparam logic [1:0] S_SCAN     = 2'd3;

  function automatic logic [PTR_BITS-1:0] phys(input logic [PTR_BITS-1:0] base,
                                               input logic [CNT_BITS-1:0] off);
    logic [CNT_BITS:0] sum;
    sum = {{(CNT_BITS+1-PTR_BITS){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_BITS+1)'(QUEUE_DEPTH))
      sum = sum - (CNT_BITS+1)'(QUEUE_DEPTH);
    return sum[PTR_BITS-1:0];
  endfunction

  logic [1:0]          state, state_next;
  logic [PTR_BITS-1:0] head, head_next;
  logic [CNT_BITS-1:0] count, count_next;
  logic [CNT_BITS-1:0] idx, idx_next;
  entry_t              item, item_next;

  entry_t              mem [QUEUE_DEPTH];
  entry_t              rd_q;
  logic                mem_we, mem_re;
  logic [PTR_BITS-1:0] mem_waddr, mem_raddr;
  entry_t              mem_wdata;

  out_beat_t           res, out_q;
  logic                emit, can_emit, key_gt;
  logic [PTR_BITS-1:0] head_dec;
  in_beat_t            in_beat;

  assign in_beat       = in_beat_t'(s_axis_tdata);
  assign can_emit      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && can_emit;
  assign key_gt        = item.key > rd_q.key;
  assign head_dec      = phys(head, CNT_BITS'(QUEUE_DEPTH - 1));
  assign m_axis_tdata  = out_q;

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    item_next  = item;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = phys(head, count);
    mem_raddr  = head;
    mem_wdata  = item;
    emit       = 1'b0;
    res        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          item_next = '{key: in_beat.item_key, data: in_beat.item_data};
          emit      = 1'b1;
          case (in_beat.cmd) inside
            CMD_PUSH_TAIL, CMD_PUSH_PRIO: begin
              if (count == CNT_BITS'(QUEUE_DEPTH)) begin
                res.status = ST_FULL;
              end else if (in_beat.cmd == CMD_PUSH_TAIL || count == '0) begin
                mem_we     = 1'b1;
                mem_wdata  = item_next;
                count_next = count + 1'b1;
              end else begin
                emit       = 1'b0;
                mem_re     = 1'b1;
                state_next = S_HEAD_CHK;
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                emit       = 1'b0;
                mem_re     = 1'b1;
                state_next = S_POP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP_RD: begin
        if (can_emit) begin
          emit          = 1'b1;
          res.out_valid = 1'b1;
          res.out_key   = rd_q.key;
          res.out_data  = rd_q.data;
          head_next     = phys(head, CNT_BITS'(1));
          count_next    = count - 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_HEAD_CHK: begin
        if (can_emit) begin
          if (key_gt) begin
            mem_we     = 1'b1;
            mem_waddr  = head_dec;
            head_next  = head_dec;
            count_next = count + 1'b1;
            emit       = 1'b1;
            state_next = S_IDLE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = phys(head, count - 1'b1);
            idx_next   = count;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (can_emit) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head, idx);
          if (key_gt) begin
            // move the smaller entry one place toward the tail
            mem_wdata = rd_q;
            mem_re    = 1'b1;
            mem_raddr = phys(head, idx - CNT_BITS'(2));
            idx_next  = idx - 1'b1;
          end else begin
            count_next = count + 1'b1;
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    res.occupancy = count_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we)
      mem[mem_waddr] <= mem_wdata;
    if (mem_re)
      rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    item <= item_next;
    if (emit)
      out_q <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (emit)
        m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)
        m_axis_tvalid <= 1'b0;
    end
  end

endmodule

>>> hdl/mfpq_checker.sv
// ----------------------------------------------------------------------------
// mfpq_checker
// Port-level checks of the mixed FIFO / priority queue.
// ----------------------------------------------------------------------------
module mfpq_checker
  import mfpq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  out_beat_t beat;
  assign beat = out_beat_t'(m_axis_tdata);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed under backpressure");

  a_occ: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> beat.occupancy <= CNT_BITS'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && beat.out_valid |-> beat.status == ST_DONE)
    else $error("popped entry with error status");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !beat.out_valid |-> beat.out_key == '0 && beat.out_data == '0)
    else $error("nonzero entry fields without a pop");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && beat.status == ST_FULL |-> beat.occupancy == CNT_BITS'(QUEUE_DEPTH))
    else $error("full refusal below depth");

endmodule

bind mixed_fifo_priority_queue mfpq_checker u_mfpq_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
